// File: hw/rtl/sacmc_pkg.sv
`default_nettype none
package sacmc_pkg;

	localparam int DEF_MAX_SETS = 1024;
	localparam int DEF_MAX_WAYS = 8;

	localparam int ADDR_W  = 32;
	localparam int TAG_W   = 32;
	localparam int STAMP_W = 32;
	localparam int CNT_W   = 32;
	localparam int ENTRY_W = 1 + TAG_W + STAMP_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SEED        = 3'd4;

	localparam logic [1:0] POL_RANDOM = 2'd0;
	localparam logic [1:0] POL_FIFO   = 2'd1;
	localparam logic [1:0] POL_LRU    = 2'd2;

	localparam logic [1:0] OUT_HIT        = 2'd0;
	localparam logic [1:0] OUT_COMPULSORY = 2'd1;
	localparam logic [1:0] OUT_CAPACITY   = 2'd2;
	localparam logic [1:0] OUT_CONFLICT   = 2'd3;

	localparam logic [4:0]  RST_OFFSET_BITS = 5'd4;
	localparam logic [3:0]  RST_INDEX_BITS  = 4'd6;
	localparam logic [3:0]  RST_WAYS        = 4'd4;
	localparam logic [1:0]  RST_POLICY      = POL_LRU;
	localparam logic [15:0] RST_SEED        = 16'd1;

	typedef struct packed {
		logic clear;
		logic accept;
		logic look;
		logic modstep;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic need_random;
		logic mod_done;
		logic out_busy;
	} sts_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == '1) ? v : v + 1'b1;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sacmc_if.sv
`default_nettype none
interface sacmc_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	modport source (output valid, output address, input ready);
	modport sink (input valid, input address, output ready);
endinterface

interface sacmc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  outcome;
	logic [2:0]  way_used;
	logic [31:0] access_total;
	logic [31:0] hit_total;
	logic [31:0] compulsory_total;
	logic [31:0] capacity_total;
	logic [31:0] conflict_total;
	modport source (output valid, output outcome, output way_used, output access_total,
		output hit_total, output compulsory_total, output capacity_total,
		output conflict_total, input ready);
	modport sink (input valid, input outcome, input way_used, input access_total,
		input hit_total, input compulsory_total, input capacity_total,
		input conflict_total, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sacmc_ram.sv
`default_nettype none
module sacmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/sacmc_ctrl.sv
`default_nettype none
module sacmc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire sacmc_pkg::sts_t sts,
	output sacmc_pkg::cmd_t     cmd
);
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_MODULO,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign req_ready = ready_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR:  cmd.clear = 1'b1;
			S_IDLE:   cmd.accept = req_valid & ready_q;
			S_LOOK:   cmd.look = 1'b1;
			S_MODULO: cmd.modstep = 1'b1;
			S_FINISH: cmd.finish = ~sts.out_busy;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clear_done) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_IDLE: begin
					if (req_valid && ready_q) begin
						state_q <= S_LOOK;
						ready_q <= 1'b0;
					end
				end
				S_LOOK: begin
					state_q <= sts.need_random ? S_MODULO : S_FINISH;
				end
				S_MODULO: begin
					if (sts.mod_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!sts.out_busy) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_CLEAR;
					ready_q <= 1'b0;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/sacmc_dp.sv
`default_nettype none
module sacmc_dp #(
	parameter int MAX_SETS = sacmc_pkg::DEF_MAX_SETS,
	parameter int MAX_WAYS = sacmc_pkg::DEF_MAX_WAYS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [sacmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sacmc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	input  wire logic [31:0]                      req_address,
	input  wire sacmc_pkg::cmd_t                  cmd,
	output sacmc_pkg::sts_t                       sts,
	input  wire logic                             rsp_ready,
	output logic                                  rsp_valid,
	output logic [1:0]                            rsp_outcome,
	output logic [2:0]                            rsp_way_used,
	output logic [31:0]                           rsp_access_total,
	output logic [31:0]                           rsp_hit_total,
	output logic [31:0]                           rsp_compulsory_total,
	output logic [31:0]                           rsp_capacity_total,
	output logic [31:0]                           rsp_conflict_total
);
	localparam int EW    = sacmc_pkg::ENTRY_W;
	localparam int SW    = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
	localparam int WW    = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
	localparam int CW    = $clog2(MAX_WAYS + 1);
	localparam int NP    = 1 << WW;
	localparam int MIB   = $clog2(MAX_SETS + 1) - 1;
	localparam int LW    = $clog2(MAX_SETS * MAX_WAYS + 1);
	localparam int CLRW  = $clog2(MAX_SETS + 1);
	localparam int ROW_W = MAX_WAYS * EW;
	localparam int TW    = sacmc_pkg::TAG_W;
	localparam int STW   = sacmc_pkg::STAMP_W;

	logic [4:0]  off_q;
	logic [3:0]  ib_q;
	logic [3:0]  ways_q;
	logic [1:0]  pol_q;
	logic [15:0] lfsr_q;

	logic [3:0]    ib_eff;
	logic [CW-1:0] ways_eff;
	logic [31:0]   shifted;
	logic [SW-1:0] set_c;
	logic [TW-1:0] tag_c;

	logic [SW-1:0]    set_q;
	logic [TW-1:0]    tag_q;
	logic [ROW_W-1:0] row_q;
	logic             hit_q, empty_q;
	logic [WW-1:0]    hit_way_q, empty_way_q, min_way_q;

	logic [ROW_W-1:0] rdata;
	logic [ROW_W-1:0] wrow;
	logic [SW-1:0]    waddr;
	logic             we;

	logic [CLRW-1:0]  clr_q;
	logic [CW-1:0]    rem_q;
	logic [3:0]       bit_q;
	logic [CW:0]      rem_sh;

	logic [sacmc_pkg::CNT_W-1:0] clock_q, acc_q, hitc_q, comp_q, capc_q, conf_q;
	logic [LW-1:0]               vbc_q;
	logic [LW-1:0]               cap_lim;

	logic          hit_c, empty_c;
	logic [WW-1:0] hit_way_c, empty_way_c;
	logic          nv [2*NP];
	logic [STW-1:0] ns [2*NP];
	logic [WW-1:0] ni [2*NP];
	logic          pick_r;

	logic [WW-1:0]  way_sel;
	logic [1:0]     outcome_c;
	logic [STW-1:0] clock_next;
	logic [15:0]    lfsr_next;

	always_comb begin
		ib_eff = (int'(ib_q) > MIB) ? 4'(MIB) : ib_q;
		if (ways_q == 4'd0) begin
			ways_eff = CW'(1);
		end else if (int'(ways_q) > MAX_WAYS) begin
			ways_eff = CW'(MAX_WAYS);
		end else begin
			ways_eff = CW'(ways_q);
		end
		shifted = req_address >> off_q;
		set_c   = SW'(shifted & ~(32'hFFFF_FFFF << ib_eff));
		tag_c   = req_address >> (6'(off_q) + 6'(ib_eff));
	end

	assign lfsr_next = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};

	always_comb begin
		hit_c       = 1'b0;
		empty_c     = 1'b0;
		hit_way_c   = '0;
		empty_way_c = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (w < int'(ways_eff)) begin
				if (rdata[w*EW + TW + STW] && rdata[w*EW + STW +: TW] == tag_q) begin
					hit_c     = 1'b1;
					hit_way_c = WW'(w);
				end
				if (!rdata[w*EW + TW + STW]) begin
					empty_c     = 1'b1;
					empty_way_c = WW'(w);
				end
			end
		end
	end

	always_comb begin
		pick_r = 1'b0;
		for (int n = 0; n < 2 * NP; n++) begin
			nv[n] = 1'b0;
			ns[n] = '0;
			ni[n] = '0;
		end
		for (int w = 0; w < NP; w++) begin
			if (w < MAX_WAYS) begin
				nv[NP + w] = (w < int'(ways_eff));
				ns[NP + w] = rdata[(w < MAX_WAYS ? w : 0)*EW +: STW];
			end
			ni[NP + w] = WW'(w);
		end
		for (int n = NP - 1; n >= 1; n--) begin
			pick_r = nv[2*n+1] && (!nv[2*n] || ns[2*n+1] < ns[2*n]);
			nv[n]  = nv[2*n] | nv[2*n+1];
			ns[n]  = pick_r ? ns[2*n+1] : ns[2*n];
			ni[n]  = pick_r ? ni[2*n+1] : ni[2*n];
		end
	end

	always_comb begin
		sts.clear_done  = (clr_q == CLRW'(MAX_SETS - 1));
		sts.need_random = ~hit_c & ~empty_c & (pol_q == sacmc_pkg::POL_RANDOM);
		sts.mod_done    = (bit_q == 4'd0);
		sts.out_busy    = rsp_valid & ~rsp_ready;
	end

	assign rem_sh  = {rem_q, lfsr_q[bit_q]};
	assign cap_lim = LW'(ways_eff) << ib_eff;
	assign clock_next = sacmc_pkg::sat_inc(clock_q);

	always_comb begin
		if (hit_q) begin
			way_sel   = hit_way_q;
			outcome_c = sacmc_pkg::OUT_HIT;
		end else if (empty_q) begin
			way_sel   = empty_way_q;
			outcome_c = sacmc_pkg::OUT_COMPULSORY;
		end else begin
			outcome_c = (vbc_q >= cap_lim) ? sacmc_pkg::OUT_CAPACITY
				: sacmc_pkg::OUT_CONFLICT;
			case (pol_q)
				sacmc_pkg::POL_RANDOM: way_sel = WW'(rem_q);
				sacmc_pkg::POL_FIFO, sacmc_pkg::POL_LRU: way_sel = min_way_q;
				default: way_sel = '0;
			endcase
		end
	end

	always_comb begin
		wrow = row_q;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WW'(w) == way_sel) begin
				if (!hit_q) begin
					wrow[w*EW +: EW] = {1'b1, tag_q, clock_next};
				end else if (pol_q == sacmc_pkg::POL_LRU) begin
					wrow[w*EW +: STW] = clock_next;
				end
			end
		end
		if (cmd.clear) begin
			wrow  = '0;
			waddr = clr_q[SW-1:0];
		end else begin
			waddr = set_q;
		end
		we = cmd.clear | cmd.finish;
	end

	sacmc_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_SETS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wrow),
		.re   (cmd.accept),
		.raddr(set_c),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q     <= sacmc_pkg::RST_OFFSET_BITS;
			ib_q      <= sacmc_pkg::RST_INDEX_BITS;
			ways_q    <= sacmc_pkg::RST_WAYS;
			pol_q     <= sacmc_pkg::RST_POLICY;
			lfsr_q    <= sacmc_pkg::RST_SEED;
			clr_q     <= '0;
			clock_q   <= '0;
			acc_q     <= '0;
			hitc_q    <= '0;
			comp_q    <= '0;
			capc_q    <= '0;
			conf_q    <= '0;
			vbc_q     <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					sacmc_pkg::REG_OFFSET_BITS: off_q <= cfg_wr_data[4:0];
					sacmc_pkg::REG_INDEX_BITS:  ib_q <= cfg_wr_data[3:0];
					sacmc_pkg::REG_WAYS:        ways_q <= cfg_wr_data[3:0];
					sacmc_pkg::REG_POLICY:      pol_q <= cfg_wr_data[1:0];
					sacmc_pkg::REG_SEED:
						lfsr_q <= (cfg_wr_data == '0) ? 16'd1 : cfg_wr_data;
					default: ;
				endcase
			end
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.look && sts.need_random) begin
				lfsr_q <= lfsr_next;
			end
			if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			if (cmd.finish) begin
				rsp_valid <= 1'b1;
				clock_q   <= clock_next;
				acc_q     <= sacmc_pkg::sat_inc(acc_q);
				case (outcome_c)
					sacmc_pkg::OUT_HIT:        hitc_q <= sacmc_pkg::sat_inc(hitc_q);
					sacmc_pkg::OUT_COMPULSORY: comp_q <= sacmc_pkg::sat_inc(comp_q);
					sacmc_pkg::OUT_CAPACITY:   capc_q <= sacmc_pkg::sat_inc(capc_q);
					default:                   conf_q <= sacmc_pkg::sat_inc(conf_q);
				endcase
				if (!hit_q && empty_q) begin
					vbc_q <= vbc_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			set_q <= set_c;
			tag_q <= tag_c;
		end
		if (cmd.look) begin
			row_q       <= rdata;
			hit_q       <= hit_c;
			hit_way_q   <= hit_way_c;
			empty_q     <= empty_c;
			empty_way_q <= empty_way_c;
			min_way_q   <= ni[1];
			rem_q       <= '0;
			bit_q       <= 4'd15;
		end
		if (cmd.modstep) begin
			rem_q <= (rem_sh >= (CW+1)'(ways_eff)) ? CW'(rem_sh - (CW+1)'(ways_eff))
				: CW'(rem_sh);
			bit_q <= bit_q - 1'b1;
		end
		if (cmd.finish) begin
			rsp_outcome          <= outcome_c;
			rsp_way_used         <= 3'(way_sel);
			rsp_access_total     <= sacmc_pkg::sat_inc(acc_q);
			rsp_hit_total        <= (outcome_c == sacmc_pkg::OUT_HIT)
				? sacmc_pkg::sat_inc(hitc_q) : hitc_q;
			rsp_compulsory_total <= (outcome_c == sacmc_pkg::OUT_COMPULSORY)
				? sacmc_pkg::sat_inc(comp_q) : comp_q;
			rsp_capacity_total   <= (outcome_c == sacmc_pkg::OUT_CAPACITY)
				? sacmc_pkg::sat_inc(capc_q) : capc_q;
			rsp_conflict_total   <= (outcome_c == sacmc_pkg::OUT_CONFLICT)
				? sacmc_pkg::sat_inc(conf_q) : conf_q;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/set_assoc_cache_miss_classifier.sv
// Set-associative tag store with miss classification. Each request carries one
// byte address; the block reads the whole set row from a single-port-write,
// registered-read RAM, compares all ways in use, then writes the updated row
// back and returns the outcome (hit, compulsory, capacity or conflict miss),
// the way touched and saturating running counts. A request passes accept/read,
// compare and write-back steps, write-back waiting on a pending response; a
// random-policy replacement adds a bit-serial victim remainder step. On reset a
// clearing pass writes all MAX_SETS rows, one per cycle, before the first
// request is taken. Configuration writes are expected only while idle.
`default_nettype none
module set_assoc_cache_miss_classifier #(
	parameter int MAX_SETS = sacmc_pkg::DEF_MAX_SETS,
	parameter int MAX_WAYS = sacmc_pkg::DEF_MAX_WAYS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [sacmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sacmc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	sacmc_req_if.sink                             req,
	sacmc_rsp_if.source                           rsp
);
	sacmc_pkg::cmd_t cmd;
	sacmc_pkg::sts_t sts;

	sacmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sacmc_dp #(
		.MAX_SETS(MAX_SETS),
		.MAX_WAYS(MAX_WAYS)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_index           (cfg_index),
		.cfg_wr_data         (cfg_wr_data),
		.req_address         (req.address),
		.cmd                 (cmd),
		.sts                 (sts),
		.rsp_ready           (rsp.ready),
		.rsp_valid           (rsp.valid),
		.rsp_outcome         (rsp.outcome),
		.rsp_way_used        (rsp.way_used),
		.rsp_access_total    (rsp.access_total),
		.rsp_hit_total       (rsp.hit_total),
		.rsp_compulsory_total(rsp.compulsory_total),
		.rsp_capacity_total  (rsp.capacity_total),
		.rsp_conflict_total  (rsp.conflict_total)
	);
endmodule
`default_nettype wire
